>>> hw/rtl/rltd_pkg.sv
// Shared constants and beat types for the run-length text decoder.
package rltd_pkg;

   // Character codes the parser reacts to
   localparam logic [7:0] QUOTE_BYTE = 8'h27;
   localparam logic [7:0] DIGIT_LO   = 8'h30;
   localparam logic [7:0] DIGIT_HI   = 8'h39;

   // Count accumulator width default and fixed width of the run_count field
   localparam int COUNT_WIDTH_DEF = 20;
   localparam int RUN_COUNT_W     = 20;

   // Request beat: one byte of a coded token
   typedef struct packed {
      logic [7:0] in_byte;
      logic       token_end;
   } req_item_type;

   // Response beat: one finished run and/or end-of-token status
   typedef struct packed {
      logic                   run_valid;
      logic [7:0]             run_char;
      logic [RUN_COUNT_W-1:0] run_count;
      logic                   line_done;
      logic                   line_error;
   } rsp_item_type;

   // Registered request beat handed from the input stage to the parser
   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

endpackage

>>> hw/rtl/rltd_ifs.sv
// Valid/ready channel interfaces for the request and response sides.
interface rltd_req_if import rltd_pkg::*;;
   logic         valid;
   logic         ready;
   req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rltd_rsp_if import rltd_pkg::*;;
   logic         valid;
   logic         ready;
   rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/run_length_text_decoder.sv
// Top level of the run-length text decoder.
//
// Bytes of a coded token arrive as request beats on req_chan (in_byte,
// token_end). Each run is a decimal count followed by one literal
// non-digit, non-quote byte or by a digit in single quotes. A finished
// run with a nonzero count gives one response beat on rsp_chan carrying the
// character and count; the last byte of a token always gives a response beat
// with line_done set, and line_error set if the token was misformed.
// Throughput: one request beat per cycle while rsp_chan.ready stays high.
// An accepted request beat is captured in the input register, and the
// parser then loads its response beat into the response register.
// A byte that neither completes a run nor ends a token gives no response beat.
// Reset clears the parser to the start of a token and empties both stages.
// When the receiver holds rsp_chan.ready low, the response register holds
// its beat, the input register fills, and req_chan.ready drops once both
// stages are full; nothing is lost.
module run_length_text_decoder import rltd_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   rltd_req_if.sink    req_chan,
   rltd_rsp_if.source  rsp_chan
);

   stage_type stage_beat;
   logic      stage_take;

   rltd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .stage_take (stage_take),
      .stage_out  (stage_beat)
   );

   rltd_parser #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .stage_in   (stage_beat),
      .stage_take (stage_take),
      .rsp_chan   (rsp_chan)
   );

endmodule

>>> hw/rtl/rltd_in_stage.sv
// Input register stage: captures one request beat per cycle while the parser keeps taking beats.
module rltd_in_stage import rltd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   rltd_req_if.sink       req_chan,
   input  logic           stage_take,
   output stage_type      stage_out
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   // Accept when empty or when the held beat leaves this cycle
   assign req_chan.ready = !valid_ff || stage_take;
   assign load           = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (stage_take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold payload until replaced
   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= req_chan.data;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.item  = item_ff;

endmodule

>>> hw/rtl/rltd_parser.sv
// Run parser: phase state, count accumulator and response register.
module rltd_parser import rltd_pkg::*; #(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  stage_type stage_in,
   output logic      stage_take,
   rltd_rsp_if.source rsp_chan
);

   localparam int WideW = COUNT_WIDTH + 4;

   typedef enum logic [2:0] {
      PH_START  = 3'd0,
      PH_COUNT  = 3'd1,
      PH_QOPEN  = 3'd2,
      PH_QCLOSE = 3'd3,
      PH_ERROR  = 3'd4
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [7:0]             qdigit_ff, qdigit_in;
   logic                   rsp_valid_ff;
   rsp_item_type           rsp_data_ff;

   logic                   is_digit;
   logic [3:0]             digit_val;
   logic [WideW-1:0]       count_wide, count_next;
   logic                   complete;
   logic [7:0]             run_ch;
   logic                   take;
   logic                   produce;
   rsp_item_type           result;
   logic [COUNT_WIDTH+RUN_COUNT_W-1:0] count_ext;

   // Advance when the response register is free or being drained
   assign stage_take = !rsp_valid_ff || rsp_chan.ready;
   assign take       = stage_in.valid && stage_take;

   assign is_digit   = stage_in.item.in_byte inside {[DIGIT_LO:DIGIT_HI]};
   assign digit_val  = stage_in.item.in_byte[3:0];
   assign count_wide = {4'b0000, count_ff};
   assign count_next = (count_wide << 3) + (count_wide << 1) + WideW'(digit_val);
   assign count_ext  = {{RUN_COUNT_W{1'b0}}, count_ff};

   // Next phase, accumulator and result for the byte in the input stage
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      qdigit_in = qdigit_ff;
      complete  = 1'b0;
      run_ch    = 8'h00;
      result    = '0;

      case (phase_ff)
         PH_START: begin
            if (is_digit) begin
               count_in = COUNT_WIDTH'(digit_val);
               phase_in = PH_COUNT;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_COUNT: begin
            if (is_digit) begin
               if (|count_next[WideW-1:COUNT_WIDTH]) begin
                  phase_in = PH_ERROR;
               end else begin
                  count_in = count_next[COUNT_WIDTH-1:0];
               end
            end else if (stage_in.item.in_byte == QUOTE_BYTE) begin
               phase_in = PH_QOPEN;
            end else begin
               complete = 1'b1;
               run_ch   = stage_in.item.in_byte;
            end
         end
         PH_QOPEN: begin
            if (is_digit) begin
               qdigit_in = stage_in.item.in_byte;
               phase_in  = PH_QCLOSE;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         PH_QCLOSE: begin
            if (stage_in.item.in_byte == QUOTE_BYTE) begin
               complete = 1'b1;
               run_ch   = qdigit_ff;
            end else begin
               phase_in = PH_ERROR;
            end
         end
         default: begin
            phase_in = PH_ERROR;
         end
      endcase

      // Close the run; a zero count yields no run
      if (complete) begin
         if (count_ff != '0) begin
            result.run_valid = 1'b1;
            result.run_char  = run_ch;
            result.run_count = count_ext[RUN_COUNT_W-1:0];
         end
         count_in  = '0;
         qdigit_in = 8'h00;
         phase_in  = PH_START;
      end

      // Token end: report status and drop back to the start state
      if (stage_in.item.token_end) begin
         result.line_done  = 1'b1;
         result.line_error = (phase_in != PH_START);
         phase_in  = PH_START;
         count_in  = '0;
         qdigit_in = 8'h00;
      end
   end

   assign produce = result.run_valid || result.line_done;

   // Parser state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_START;
         count_ff     <= '0;
         qdigit_ff    <= 8'h00;
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         qdigit_ff    <= qdigit_in;
         rsp_valid_ff <= produce;
         if (produce) begin
            rsp_data_ff <= result;
         end
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_data_ff;

endmodule

>>> test/run_length_text_decoder_test.sv
// Self-checking testbench for the run-length text decoder: directed, back-pressure and random tokens.
`timescale 1ns / 1ps

module run_length_text_decoder_test;
   import rltd_pkg::*;

   typedef logic [7:0] code_bytes_type[$];

   typedef enum logic [2:0] {
      SCAN_START,
      SCAN_COUNT,
      SCAN_QUOTE_OPEN,
      SCAN_QUOTE_CLOSE,
      SCAN_ERROR
   } scan_phase_type;

   localparam longint unsigned COUNT_LIMIT = (64'd1 << COUNT_WIDTH_DEF) - 64'd1;
   localparam int MAX_IDLE = 17;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rltd_req_if req_bus ();
   rltd_rsp_if rsp_bus ();

   run_length_text_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   // Parser state mirrored on the testbench side
   scan_phase_type  scan_phase = SCAN_START;
   longint unsigned run_total = 0;
   logic [7:0]      quote_digit = '0;

   // Run beats decoded from accepted bytes, oldest first
   rsp_item_type parsed_beats[$];

   int failure_total = 0;
   int bytes_sent = 0;
   int req_gap_max = MAX_IDLE;
   int rsp_stall_max = MAX_IDLE;
   int rsp_hold_cycles = 0;

   always #6 clock = ~clock;

   // Advance the parse by one byte; return 1 when the byte yields a response beat
   function automatic bit parse_run_byte(input req_item_type item, output rsp_item_type beat);
      logic [7:0]      b;
      bit              is_digit;
      bit              complete;
      logic [7:0]      run_ch;
      longint unsigned next_count;
      b = item.in_byte;
      is_digit = (b >= DIGIT_LO) && (b <= DIGIT_HI);
      complete = 1'b0;
      run_ch = '0;
      beat = '0;
      case (scan_phase)
         SCAN_START: begin
            if (is_digit) begin
               run_total = b - DIGIT_LO;
               scan_phase = SCAN_COUNT;
            end else begin
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_COUNT: begin
            if (is_digit) begin
               next_count = run_total * 10 + (b - DIGIT_LO);
               if (next_count > COUNT_LIMIT) begin
                  scan_phase = SCAN_ERROR;
               end else begin
                  run_total = next_count;
               end
            end else if (b == QUOTE_BYTE) begin
               scan_phase = SCAN_QUOTE_OPEN;
            end else begin
               complete = 1'b1;
               run_ch = b;
            end
         end
         SCAN_QUOTE_OPEN: begin
            if (is_digit) begin
               quote_digit = b;
               scan_phase = SCAN_QUOTE_CLOSE;
            end else begin
               scan_phase = SCAN_ERROR;
            end
         end
         SCAN_QUOTE_CLOSE: begin
            if (b == QUOTE_BYTE) begin
               complete = 1'b1;
               run_ch = quote_digit;
            end else begin
               scan_phase = SCAN_ERROR;
            end
         end
         default: begin
            scan_phase = SCAN_ERROR;
         end
      endcase

      // Close the run; a zero count gives no run beat
      if (complete) begin
         if (run_total != 0) begin
            beat.run_valid = 1'b1;
            beat.run_char = run_ch;
            beat.run_count = run_total[RUN_COUNT_W-1:0];
         end
         run_total = 0;
         quote_digit = '0;
         scan_phase = SCAN_START;
      end

      // Report the line status and start over on the last byte
      if (item.token_end) begin
         beat.line_done = 1'b1;
         beat.line_error = (scan_phase != SCAN_START);
         scan_phase = SCAN_START;
         run_total = 0;
         quote_digit = '0;
      end
      return beat.run_valid || beat.line_done;
   endfunction

   // Offer one byte after a random gap and hold it until accepted
   task automatic send_code_byte(input logic [7:0] b, input logic last);
      int           gap;
      req_item_type item;
      rsp_item_type beat;
      gap = $urandom_range(req_gap_max, 0);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      item.in_byte = b;
      item.token_end = last;
      req_bus.data <= item;
      req_bus.valid <= 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      bytes_sent++;
      if (parse_run_byte(item, beat)) begin
         parsed_beats.push_back(beat);
      end
   endtask

   // Send a whole token, marking its last byte
   task automatic send_token(input code_bytes_type code);
      foreach (code[i]) begin
         send_code_byte(code[i], i == code.size() - 1);
      end
   endtask

   // Drop valid and wait until every run beat has come back
   task automatic wait_for_drain();
      req_bus.valid <= 1'b0;
      while (parsed_beats.size() != 0) @(posedge clock);
   endtask

   // Compare one response beat with the oldest decoded run
   task automatic check_run_beat(input rsp_item_type got);
      rsp_item_type want;
      if (parsed_beats.size() == 0) begin
         $error("unexpected response beat: run_valid %0d char %0h count %0d done %0d err %0d",
                got.run_valid, got.run_char, got.run_count, got.line_done, got.line_error);
         failure_total++;
         return;
      end
      want = parsed_beats.pop_front();
      if (got.run_valid !== want.run_valid) begin
         $error("run_valid: expected %0d, actual %0d", want.run_valid, got.run_valid);
         failure_total++;
      end
      if (got.run_char !== want.run_char) begin
         $error("run_char: expected %0h, actual %0h", want.run_char, got.run_char);
         failure_total++;
      end
      if (got.run_count !== want.run_count) begin
         $error("run_count: expected %0d, actual %0d", want.run_count, got.run_count);
         failure_total++;
      end
      if (got.line_done !== want.line_done) begin
         $error("line_done: expected %0d, actual %0d", want.line_done, got.line_done);
         failure_total++;
      end
      if (got.line_error !== want.line_error) begin
         $error("line_error: expected %0d, actual %0d", want.line_error, got.line_error);
         failure_total++;
      end
   endtask

   // Receive response beats with random stalls, or one long hold when asked
   initial begin
      int stall;
      rsp_bus.ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = $urandom_range(rsp_stall_max, 0);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
         check_run_beat(rsp_bus.data);
      end
   end

   // Cover each form of run and each way a token goes bad
   task automatic test_directed_runs();
      code_bytes_type code;
      // start byte not a digit
      code = '{"a"};
      send_token(code);
      // leading zeros, zero count on a NUL literal, quoted digit closing the token
      code = '{"0", "0", "7", "a", "0", 8'h00, "3", QUOTE_BYTE, "7", QUOTE_BYTE};
      send_token(code);
      // quoted byte not a digit; the bytes after it are ignored
      code = '{"1", QUOTE_BYTE, "a", "5", "b"};
      send_token(code);
      // largest count with the top byte value as literal
      code = '{"1", "0", "4", "8", "5", "7", "5", 8'hFF};
      send_token(code);
      // token ends inside a count, then inside an open quote
      code = '{"5"};
      send_token(code);
      code = '{"2", QUOTE_BYTE};
      send_token(code);
   endtask

   // Hold the receiver off while bytes keep coming so both stages fill
   task automatic test_output_stall();
      code_bytes_type code;
      wait_for_drain();
      req_gap_max = 0;
      rsp_hold_cycles = 120;
      for (int i = 0; i < 20; i++) begin
         code.push_back(DIGIT_LO + 8'(1 + i % 9));
         code.push_back(8'h61 + 8'(i));
      end
      send_token(code);
      wait_for_drain();
      req_gap_max = MAX_IDLE;
   endtask

   // Build mostly well-formed tokens with random runs; corrupt some of them
   task automatic send_random_token();
      code_bytes_type code;
      logic [7:0]     digits[$];
      logic [7:0]     lit;
      int unsigned    count;
      int             kind;
      int             runs;
      runs = $urandom_range(4, 1);
      for (int r = 0; r < runs; r++) begin
         kind = $urandom_range(9, 0);
         case (kind)
            0, 1, 2, 3, 4: count = $urandom_range(9, 0);
            5, 6:          count = $urandom_range(999, 10);
            7:             count = $urandom_range(99, 0);
            8:             count = $urandom_range(1048575, 1048500);
            default:       count = $urandom_range(9999999, 1048576);
         endcase
         digits.delete();
         do begin
            digits.push_front(DIGIT_LO + 8'(count % 10));
            count = count / 10;
         end while (count != 0);
         if (kind == 7) begin
            repeat ($urandom_range(3, 1)) digits.push_front(DIGIT_LO);
         end
         code = {code, digits};
         if ($urandom_range(9, 0) < 6) begin
            do lit = 8'($urandom_range(255, 0));
            while ((lit >= DIGIT_LO && lit <= DIGIT_HI) || lit == QUOTE_BYTE);
            code.push_back(lit);
         end else begin
            code.push_back(QUOTE_BYTE);
            code.push_back(DIGIT_LO + 8'($urandom_range(9, 0)));
            code.push_back(QUOTE_BYTE);
         end
      end

      // Break about one token in six
      if ($urandom_range(5, 0) == 0) begin
         case ($urandom_range(3, 0))
            0: code[$urandom_range(code.size() - 1, 0)] = 8'($urandom_range(255, 0));
            1: begin
               if (code.size() > 1) begin
                  code.delete(code.size() - 1);
               end else begin
                  code[0] = 8'($urandom_range(255, 0));
               end
            end
            2: code.insert($urandom_range(code.size(), 0), QUOTE_BYTE);
            default: begin
               code.delete();
               repeat ($urandom_range(6, 1)) code.push_back(8'($urandom_range(255, 0)));
            end
         endcase
      end
      send_token(code);
   endtask

   // Random tokens in stretches with different idle patterns on each side
   task automatic test_random_tokens();
      int stop_at;
      for (int stretch = 0; stretch < 4; stretch++) begin
         req_gap_max = (stretch == 1 || stretch == 2) ? 0 : MAX_IDLE;
         rsp_stall_max = (stretch == 1 || stretch == 3) ? 0 : MAX_IDLE;
         stop_at = bytes_sent + 250;
         while (bytes_sent < stop_at) send_random_token();
      end
      req_gap_max = MAX_IDLE;
      rsp_stall_max = MAX_IDLE;
   endtask

   initial begin
      req_bus.valid = 1'b0;
      req_bus.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed_runs();
      test_output_stall();
      test_random_tokens();

      // Let the pipeline settle, then report
      wait_for_drain();
      repeat (10) @(posedge clock);
      if (failure_total == 0) begin
         $display("run_length_text_decoder regression: pass");
      end else begin
         $display("run_length_text_decoder regression: fail");
      end
      $finish;
   end

   // Stop a hung run
   initial begin
      #10_000_000;
      $display("run_length_text_decoder regression: fail");
      $finish;
   end

endmodule
